// ===== sv/lsb_pkg.sv =====
// Package for the lane steering blend unit: types, constants and the CORDIC angle table.
package lsb_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned TableLen = 24;

  localparam logic [1:0] RegFilterWeight = 2'd0;
  localparam logic [1:0] RegWheelBase    = 2'd1;
  localparam logic [1:0] RegLookahead    = 2'd2;
  localparam logic [1:0] RegOffsetGain   = 2'd3;

  // Pi in Q2.30 split as 46080 * PiQ30Hi + PiQ30Lo, so that the degree to radian
  // step needs only a small remainder division by 46080.
  localparam logic [16:0] PiQ30Hi = 17'd73204;
  localparam logic [14:0] PiQ30Lo = 15'd19106;
  // ceil(2^25 / 45) and ceil(2^26 / 5); both are exact over the operand ranges used.
  localparam logic [19:0] Recip45 = 20'd745655;
  localparam logic [23:0] Recip5  = 24'd13421773;

  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;

  typedef struct packed {
    logic [16:0] filter_weight;
    logic [13:0] wbase_mm;
    logic [15:0] lookahead_mm;
    logic [15:0] offset_gain;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat and run the filter
    logic prep;      // form the angle and the starting vector
    logic rot_step;  // one rotation-mode iteration
    logic vec_init;  // start vectoring mode
    logic vec_step;  // one vectoring-mode iteration
    logic fin1;      // round the pursuit angle and form the blend numerator
    logic fin2;      // divide the blend numerator
    logic put;       // move the result into the output register
    logic [4:0] iter;
  } lsb_cmd_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd843314857;
        5'd1: r = 32'sd497837829;
        5'd2: r = 32'sd263043837;
        5'd3: r = 32'sd133525159;
        5'd4: r = 32'sd67021687;
        5'd5: r = 32'sd33543516;
        5'd6: r = 32'sd16775851;
        5'd7: r = 32'sd8388437;
        5'd8: r = 32'sd4194283;
        5'd9: r = 32'sd2097149;
        5'd10: r = 32'sd1048576;
        5'd11: r = 32'sd524288;
        5'd12: r = 32'sd262144;
        5'd13: r = 32'sd131072;
        5'd14: r = 32'sd65536;
        5'd15: r = 32'sd32768;
        5'd16: r = 32'sd16384;
        5'd17: r = 32'sd8192;
        5'd18: r = 32'sd4096;
        5'd19: r = 32'sd2048;
        5'd20: r = 32'sd1024;
        5'd21: r = 32'sd512;
        5'd22: r = 32'sd256;
        5'd23: r = 32'sd128;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== sv/lsb_if.sv =====
// Valid/ready channel interfaces for the lane steering blend unit.
interface lsb_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] lane_offset;
  logic signed [15:0] lane_angle;
  modport source (output valid, output lane_offset, output lane_angle, input ready);
  modport sink (input valid, input lane_offset, input lane_angle, output ready);
endinterface

interface lsb_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] steering;
  logic signed [15:0] pursuit_steering;
  logic signed [15:0] offset_term;
  logic signed [15:0] smoothed_offset;
  modport source (output valid, output steering, output pursuit_steering,
                  output offset_term, output smoothed_offset, input ready);
  modport sink (input valid, input steering, input pursuit_steering,
                input offset_term, input smoothed_offset, output ready);
endinterface

interface lsb_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [16:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/lane_steering_blend_unit.sv =====
// Lane steering blend unit: takes one lane measurement beat (offset and heading) and returns
// one steering result beat. The filtered offset is updated at the accepting edge. A single
// shared CORDIC runs rotation mode for the sine and then vectoring mode for the atan2, one
// iteration per cycle and CORDIC_STEPS iterations each way (capped at 24). After the accepting
// edge the beat passes through the states PREP, ROT, VINIT, VEC, FIN1, FIN2 and PUT, where the
// result is loaded into the output register, and only then can a new beat be taken. The input is
// not ready while a beat is being worked on, and a result still waiting in the output register
// holds the next one back until it is taken. The configuration port is always ready and is
// meant to be written only while no beat is in flight.
module lane_steering_blend_unit #(
  parameter int unsigned CORDIC_STEPS = lsb_pkg::CordicStepsDef
) (
  input logic clk,
  input logic rst_n,
  lsb_in_if.sink    in_ch,
  lsb_out_if.source out_ch,
  lsb_cfg_if.sink   cfg_ch
);
  import lsb_pkg::*;

  cfg_t     cfg_r;
  lsb_cmd_t cmd;
  logic     out_load;
  logic     out_valid_r;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_weight <= 17'd32768;
      cfg_r.wbase_mm      <= 14'd3000;
      cfg_r.lookahead_mm  <= 16'd5000;
      cfg_r.offset_gain   <= 16'd256;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegFilterWeight: cfg_r.filter_weight <= cfg_ch.data;
        RegWheelBase:    cfg_r.wbase_mm      <= cfg_ch.data[13:0];
        RegLookahead:    cfg_r.lookahead_mm  <= cfg_ch.data[15:0];
        RegOffsetGain:   cfg_r.offset_gain   <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  lsb_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_valid_r && !out_ch.ready),
    .out_load,
    .cmd
  );

  lsb_dp u_dp (
    .clk, .rst_n,
    .cfg              (cfg_r),
    .cmd,
    .lane_offset      (in_ch.lane_offset),
    .lane_angle       (in_ch.lane_angle),
    .steering         (out_ch.steering),
    .pursuit_steering (out_ch.pursuit_steering),
    .offset_term      (out_ch.offset_term),
    .smoothed_offset  (out_ch.smoothed_offset)
  );

`ifndef NO_ASSERTIONS
  a_one_owner: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !cmd.rot_step && !cmd.vec_step) else $error("busy while ready");
  a_load_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !in_ch.ready) else $error("result load while idle");
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result dropped");
  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_ch.steering) &&
    $stable(out_ch.smoothed_offset)) else $error("result changed while waiting");
`endif
endmodule

// ===== sv/lsb_ctrl.sv =====
// Controller state machine that sequences one beat through the datapath.
module lsb_ctrl #(
  parameter int unsigned CORDIC_STEPS = lsb_pkg::CordicStepsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  output logic              out_load,
  output lsb_pkg::lsb_cmd_t cmd
);
  import lsb_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
  localparam logic [4:0] LastIter = 5'(Steps - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ROT, S_VINIT, S_VEC, S_FIN1, S_FIN2, S_PUT
  } state_t;

  state_t     state_r;
  logic [4:0] iter_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.iter = iter_r;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE:  cmd.load = in_valid;
      S_PREP:  cmd.prep = 1'b1;
      S_ROT:   cmd.rot_step = 1'b1;
      S_VINIT: cmd.vec_init = 1'b1;
      S_VEC:   cmd.vec_step = 1'b1;
      S_FIN1:  cmd.fin1 = 1'b1;
      S_FIN2:  cmd.fin2 = 1'b1;
      S_PUT: begin
        out_load = !out_busy;
        cmd.put  = !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_PREP;
        S_PREP: begin
          iter_r  <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          iter_r <= iter_r + 5'd1;
          if (iter_r == LastIter) state_r <= S_VINIT;
        end
        S_VINIT: begin
          iter_r  <= '0;
          state_r <= S_VEC;
        end
        S_VEC: begin
          iter_r <= iter_r + 5'd1;
          if (iter_r == LastIter) state_r <= S_FIN1;
        end
        S_FIN1: state_r <= S_FIN2;
        S_FIN2: state_r <= S_PUT;
        S_PUT:  if (!out_busy) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/lsb_dp.sv =====
// Datapath: offset filter, shared CORDIC, offset term and blend.
module lsb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lsb_pkg::cfg_t       cfg,
  input  lsb_pkg::lsb_cmd_t   cmd,
  input  logic signed [15:0]  lane_offset,
  input  logic signed [15:0]  lane_angle,
  output logic signed [15:0]  steering,
  output logic signed [15:0]  pursuit_steering,
  output logic signed [15:0]  offset_term,
  output logic signed [15:0]  smoothed_offset
);
  import lsb_pkg::*;

  logic signed [31:0] filt_r;
  logic               dneg_r;
  logic [14:0]        dmag_r;
  logic [18:0]        mlo_r;
  logic signed [47:0] x_r, y_r;
  logic signed [34:0] z_r;
  logic signed [17:0] pur_r;
  logic signed [25:0] off_r;
  logic signed [27:0] num_r;
  logic signed [27:0] blend_r;

  logic [16:0]        w;
  logic signed [64:0] acc;
  logic signed [16:0] neg_a, dfold;
  logic [14:0]        dmag;
  logic [28:0]        dlo;
  logic [31:0]        rhi;
  logic [38:0]        rlop;
  logic [31:0]        rmag;
  logic signed [34:0] rad;
  logic signed [60:0] x0p;
  logic signed [47:0] x0;
  logic signed [47:0] dx, dy;
  logic               dir;
  logic signed [31:0] at;
  logic signed [48:0] offp;
  logic signed [17:0] pur;
  logic signed [27:0] num;
  logic [27:0]        anum;
  logic [24:0]        nhalf;
  logic [48:0]        qp;
  logic signed [27:0] blend;

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    if (v > 28'sd32767) return 16'sh7fff;
    if (v < -28'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    w = (cfg.filter_weight > 17'd65536) ? 17'd65536 : cfg.filter_weight;
    acc = $signed({1'b0, w}) * lane_offset * 65'sd65536
        + $signed({1'b0, 17'd65536 - w}) * filt_r;
    neg_a = -17'(lane_angle);
    if (neg_a > 17'sd23040) dfold = 17'sd46080 - neg_a;
    else if (neg_a < -17'sd23040) dfold = -17'sd46080 - neg_a;
    else dfold = neg_a;
    dmag = (dfold < 17'sd0) ? 15'(-dfold) : 15'(dfold);
    dlo = {14'd0, dmag} * {14'd0, PiQ30Lo};
    // |angle| * pi / 46080 truncated: the whole multiple plus the remainder part
    // divided by 1024 and then by 45 through a reciprocal.
    rhi = {17'd0, dmag_r} * {15'd0, PiQ30Hi};
    rlop = {20'd0, mlo_r} * {19'd0, Recip45};
    rmag = rhi + {18'd0, rlop[38:25]};
    rad = dneg_r ? -$signed({3'b0, rmag}) : $signed({3'b0, rmag});
    x0p = $signed({1'b0, cfg.wbase_mm, 15'd0}) * InvGainQ30;
    x0 = 48'(x0p >>> 30);
    dx = y_r >>> cmd.iter;
    dy = x_r >>> cmd.iter;
    dir = cmd.rot_step ? (z_r >= 0) : (y_r < 0);
    at = atan_q30(cmd.iter);
    offp = $signed({1'b0, cfg.offset_gain}) * filt_r + 49'sd4194304;
    pur = 18'((z_r + 35'sd65536) >>> 17);
    num = 28'sd7 * 28'(pur) - 28'sd3 * 28'(off_r);
    // Round half away from zero on the magnitude, then divide by 10 as a halving
    // followed by a reciprocal multiply for 5.
    anum = (num_r < 0) ? 28'(-num_r) : 28'(num_r);
    nhalf = 25'((anum + 28'd5) >> 1);
    qp = {24'd0, nhalf} * {25'd0, Recip5};
    blend = (num_r < 0) ? -$signed({5'd0, qp[48:26]}) : $signed({5'd0, qp[48:26]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (cmd.load) begin
      filt_r <= 32'(acc >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dneg_r <= (dfold < 17'sd0);
      dmag_r <= dmag;
      mlo_r  <= dlo[28:10];
    end
    if (cmd.prep) begin
      x_r <= x0;
      y_r <= '0;
      z_r <= rad;
      off_r <= 26'(offp >>> 23);
    end
    if (cmd.rot_step) begin
      if (dir) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - 35'(at);
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + 35'(at);
      end
    end
    if (cmd.vec_init) begin
      x_r <= {18'd0, cfg.lookahead_mm, 14'd0};
      z_r <= '0;
    end
    // A zero vector stays zero and leaves the angle at 0; no other start reaches it.
    if (cmd.vec_step && !(x_r == 0 && y_r == 0)) begin
      if (dir) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - 35'(at);
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + 35'(at);
      end
    end
    if (cmd.fin1) begin
      pur_r <= pur;
      num_r <= num;
    end
    if (cmd.fin2) begin
      blend_r <= blend;
    end
    if (cmd.put) begin
      steering         <= sat16(blend_r);
      pursuit_steering <= sat16(28'(pur_r));
      offset_term      <= sat16(28'(off_r));
      smoothed_offset  <= filt_r[31:16];
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the lane steering blend unit: directed and random lane beats checked against
// a fixed-point predictor.
module tb;
  import lsb_pkg::*;

  typedef struct {
    logic signed [15:0] steering;
    logic signed [15:0] pursuit;
    logic signed [15:0] offset_term;
    logic signed [15:0] smoothed;
  } steer_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  lsb_in_if  in_ch ();
  lsb_out_if out_ch ();
  lsb_cfg_if cfg_ch ();

  lane_steering_blend_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state and register copies.
  logic signed [31:0] filt_q28;
  logic [16:0] weight_q16;
  logic [13:0] wb_mm;
  logic [15:0] lookahead;
  logic [15:0] gain_q8;

  steer_res_t expected_q[$];
  int errors = 0;
  int n_beats = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(input int i);
    return longint'(atan_q30(5'(i)));
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic steer_res_t predict_steering(input logic signed [15:0] offs,
                                                  input logic signed [15:0] ang);
    steer_res_t r;
    longint w, acc, d, rad, x, y, z, dx, dy, pur, off, num, blend;
    begin
      w = (weight_q16 > 17'd65536) ? 65536 : longint'(weight_q16);
      acc = w * longint'(offs) * 65536 + (65536 - w) * longint'(filt_q28);
      filt_q28 = 32'(floor_shr(acc, 16));
      d = -longint'(ang);
      if (d > 23040) d = 46080 - d;
      else if (d < -23040) d = -46080 - d;
      rad = (d * 64'sd3373259426) / 46080;
      // Rotation mode gives the sine term scaled by 2^14.
      x = floor_shr(((2 * longint'(wb_mm)) <<< 14) * 652032874, 30);
      y = 0;
      z = rad;
      for (int i = 0; i < CordicStepsDef; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end else begin
          x += dx; y -= dy; z += atan_step(i);
        end
      end
      // Vectoring mode for the atan2 against the lookahead.
      x = longint'(lookahead) <<< 14;
      z = 0;
      if (!(x == 0 && y == 0)) begin
        for (int i = 0; i < CordicStepsDef; i++) begin
          dx = floor_shr(y, i);
          dy = floor_shr(x, i);
          if (y < 0) begin
            x -= dx; y += dy; z -= atan_step(i);
          end else begin
            x += dx; y -= dy; z += atan_step(i);
          end
        end
      end
      pur = floor_shr(z + 65536, 17);
      off = floor_shr(longint'(gain_q8) * longint'(filt_q28) + (longint'(1) <<< 22), 23);
      num = 7 * pur - 3 * off;
      blend = (num >= 0) ? (num + 5) / 10 : -((-num + 5) / 10);
      r.steering = sat16(blend);
      r.pursuit = sat16(pur);
      r.offset_term = sat16(off);
      r.smoothed = 16'(floor_shr(longint'(filt_q28), 16));
      return r;
    end
  endfunction

  task automatic send_lane(input logic signed [15:0] offs, input logic signed [15:0] ang);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.lane_offset <= offs;
    in_ch.lane_angle <= ang;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_steering(offs, ang));
    n_beats++;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      RegFilterWeight: weight_q16 = val;
      RegWheelBase:    wb_mm = val[13:0];
      RegLookahead:    lookahead = val[15:0];
      RegOffsetGain:   gain_q8 = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [16:0] w, input logic [13:0] wb,
                            input logic [15:0] la, input logic [15:0] g);
    wait_drained();
    write_reg(RegFilterWeight, w);
    write_reg(RegWheelBase, {3'b0, wb});
    write_reg(RegLookahead, {1'b0, la});
    write_reg(RegOffsetGain, {1'b0, g});
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    send_lane(16'sh7fff, 16'sd0);
    send_lane(-16'sd32768, 16'sd23040);
    send_lane(16'sd0, -16'sd23040);
    send_lane(16'sd4096, 16'sh7fff);
    send_lane(-16'sd4096, -16'sd32768);
    send_lane(16'sd100, 16'sd30000);
    send_lane(-16'sd1, -16'sd30000);
    send_lane(16'sd0, 16'sd1);
    // Weight above one, zero wheelbase with zero lookahead, then zero lookahead alone.
    set_config(17'h1ffff, 14'd0, 16'd0, 16'hffff);
    send_lane(16'sh7fff, 16'sd5000);
    send_lane(-16'sd32768, -16'sd5000);
    set_config(17'd0, 14'd16383, 16'd0, 16'd0);
    send_lane(16'sd1234, 16'sd5000);
    send_lane(16'sd1234, -16'sd5000);
    send_lane(16'sd1234, 16'sd0);
    set_config(17'd65536, 14'd16383, 16'd1, 16'hffff);
    send_lane(16'sh7fff, 16'sd23040);
    send_lane(-16'sd32768, -16'sd23040);
    set_config(17'd65536, 14'd1, 16'hffff, 16'd0);
    send_lane(16'sd2000, 16'sd23040);
    send_lane(-16'sd2000, 16'sd256);
  endtask

  task automatic random_lanes(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) send_lane(16'($urandom), 16'($urandom));
      else send_lane(16'($urandom_range(8191)) - 16'sd4096,
                     16'($urandom_range(46080)) - 16'sd23040);
    end
  endtask

  task automatic test_random();
    set_config(17'($urandom_range(65536)), 14'($urandom_range(16383, 1)),
               16'($urandom_range(65535, 1)), 16'($urandom));
    random_lanes(130, 12, 76);
    set_config(17'($urandom), 14'($urandom_range(5000, 500)),
               16'($urandom_range(20000, 1000)), 16'($urandom_range(2048)));
    random_lanes(130, 76, 12);
    set_config(17'd32768, 14'd3000, 16'd5000, 16'd256);
    random_lanes(130, 0, 0);
  endtask

  task automatic test_backpressure();
    // The receiver stalls for a long stretch while beats keep coming.
    hold_reqs++;
    random_lanes(6, 0, 0);
    wait_drained();
    random_lanes(3, 0, 0);
  endtask

  // Output side: idle pattern, long hold-off and result checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_reqs != hold_seen) begin
        hold_seen <= hold_reqs;
        hold_cycles <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual steering=%0d",
                   $time, out_ch.steering);
          errors++;
        end else begin
          steer_res_t e;
          e = expected_q.pop_front();
          if (e.steering !== out_ch.steering || e.pursuit !== out_ch.pursuit_steering ||
              e.offset_term !== out_ch.offset_term ||
              e.smoothed !== out_ch.smoothed_offset) begin
            $display("%0t: mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                     $time, e.steering, e.pursuit, e.offset_term, e.smoothed,
                     out_ch.steering, out_ch.pursuit_steering, out_ch.offset_term,
                     out_ch.smoothed_offset);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.lane_offset = '0;
    in_ch.lane_angle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    filt_q28 = 0;
    weight_q16 = 17'd32768;
    wb_mm = 14'd3000;
    lookahead = 16'd5000;
    gain_q8 = 16'd256;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    $display("Covered %0d lane beats, %0d results, register extremes and stalls.",
             n_beats, n_results);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/lsb_pkg.sv
sv/lsb_if.sv
sv/lsb_ctrl.sv
sv/lsb_dp.sv
sv/lane_steering_blend_unit.sv
tb/sv/tb.sv
